@@ hw/rtl/mbf_pkg.sv @@
`default_nettype none

package mbf_pkg;

   // chunk counter and limit register
   localparam int CHUNK_W = 11;
   localparam logic [CHUNK_W-1:0] MAX_CHUNK = CHUNK_W'(1024);
   localparam logic [CHUNK_W-1:0] CHUNK_LIMIT_RESET = CHUNK_W'(1024);
   localparam logic [CHUNK_W-1:0] CHUNK_LIMIT_MIN = CHUNK_W'(1);

   // small queues between the parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;

   // result kind codes
   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_SINGLE  = 2'd1;
   localparam logic [1:0] KIND_SYSEX   = 2'd2;

   // message length codes
   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   typedef enum logic [1:0] {
      CLS_CHAN3       = 2'd0,
      CLS_CHAN2       = 2'd1,
      CLS_SYSEX_START = 2'd2,
      CLS_SINGLE      = 2'd3
   } byte_class_type;

   typedef enum logic [4:0] {
      PH_WAIT        = 5'b00001,
      PH_NEED_ONE    = 5'b00010,
      PH_NEED_BOTH   = 5'b00100,
      PH_NEED_SECOND = 5'b01000,
      PH_SYSEX       = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0]     midi_byte;
      byte_class_type cls;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] status_byte;
      logic [7:0] data_first;
      logic [7:0] data_second;
      logic [1:0] msg_length;
      logic       chunk_last;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/mbf_front.sv @@
`default_nettype none

module mbf_front
   import mbf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [7:0] midi_byte,
   output logic            full,
   output logic            item_valid,
   output item_type        item,
   input  wire logic       item_take
);

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;
   item_type                 classified;
   logic                     accept;
   logic                     take;

   // classify by status nibble, sysex opens only on exactly f0
   always_comb begin
      classified.midi_byte = midi_byte;
      case (midi_byte[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: classified.cls = CLS_CHAN3;
         4'hC, 4'hD:                   classified.cls = CLS_CHAN2;
         default: begin
            if (midi_byte == BYTE_SYSEX_START) classified.cls = CLS_SYSEX_START;
            else                               classified.cls = CLS_SINGLE;
         end
      endcase
   end

   assign full       = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign take       = item_take && item_valid;

   always_comb begin
      wr_ptr_in = accept ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = QUEUE_CNT_W'(cnt_ff + QUEUE_CNT_W'(accept) - QUEUE_CNT_W'(take));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/mbf_back.sv @@
`default_nettype none

module mbf_back
   import mbf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire item_type           item,
   output logic                    item_take,
   input  wire logic               csr_write_en,
   input  wire logic [CHUNK_W-1:0] csr_write_data,
   input  wire logic               pop,
   output logic                    empty,
   output result_type              result
);

   phase_type               phase_ff, phase_in;
   logic [7:0]              held_status_ff, held_status_in;
   logic [7:0]              held_first_ff, held_first_in;
   logic [1:0]              held_length_ff, held_length_in;
   logic [CHUNK_W-1:0]      chunk_fill_ff, chunk_fill_in;
   logic [CHUNK_W-1:0]      limit_ff, limit_in;
   logic [CHUNK_W-1:0]      fill_inc;

   result_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  cnt_ff, cnt_in;

   logic                    emit;
   result_type              res;
   logic                    take_res;
   logic [7:0]              b;

   // limit is clamped on write
   always_comb begin
      if (csr_write_data < CHUNK_LIMIT_MIN)  limit_in = CHUNK_LIMIT_MIN;
      else if (csr_write_data > MAX_CHUNK)   limit_in = MAX_CHUNK;
      else                                   limit_in = csr_write_data;
   end

   assign item_take = item_valid && (cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign b         = item.midi_byte;
   assign fill_inc  = CHUNK_W'(chunk_fill_ff + 1'b1);

   always_comb begin
      phase_in       = phase_ff;
      held_status_in = held_status_ff;
      held_first_in  = held_first_ff;
      held_length_in = held_length_ff;
      chunk_fill_in  = chunk_fill_ff;
      emit           = 1'b0;
      res            = '0;
      res.msg_length = LEN_ONE;
      if (item_take) begin
         case (phase_ff)
            PH_NEED_BOTH: begin
               held_first_in = b;
               phase_in      = PH_NEED_SECOND;
            end
            PH_NEED_ONE: begin
               phase_in        = PH_WAIT;
               emit            = 1'b1;
               res.kind        = KIND_CHANNEL;
               res.status_byte = held_status_ff;
               res.data_first  = b;
               res.msg_length  = held_length_ff;
            end
            PH_NEED_SECOND: begin
               phase_in        = PH_WAIT;
               emit            = 1'b1;
               res.kind        = KIND_CHANNEL;
               res.status_byte = held_status_ff;
               res.data_first  = held_first_ff;
               res.data_second = b;
               res.msg_length  = held_length_ff;
            end
            PH_SYSEX: begin
               emit            = 1'b1;
               res.kind        = KIND_SYSEX;
               res.status_byte = b;
               if (b == BYTE_SYSEX_END) begin
                  res.chunk_last = 1'b1;
                  chunk_fill_in  = '0;
                  phase_in       = PH_WAIT;
               end else if (fill_inc >= limit_ff) begin
                  res.chunk_last = 1'b1;
                  chunk_fill_in  = '0;
               end else begin
                  chunk_fill_in  = fill_inc;
               end
            end
            default: begin
               // waiting for status, unused codes land here too
               phase_in = PH_WAIT;
               case (item.cls)
                  CLS_CHAN3: begin
                     held_status_in = b;
                     held_length_in = LEN_THREE;
                     phase_in       = PH_NEED_BOTH;
                  end
                  CLS_CHAN2: begin
                     held_status_in = b;
                     held_length_in = LEN_TWO;
                     phase_in       = PH_NEED_ONE;
                  end
                  CLS_SYSEX_START: begin
                     phase_in      = PH_SYSEX;
                     chunk_fill_in = '0;
                  end
                  default: begin
                     held_status_in  = b;
                     held_length_in  = LEN_ONE;
                     emit            = 1'b1;
                     res.kind        = KIND_SINGLE;
                     res.status_byte = b;
                  end
               endcase
            end
         endcase
      end
   end

   // result queue
   assign empty    = (cnt_ff == '0);
   assign result   = slot_ff[rd_ptr_ff];
   assign take_res = pop && !empty;

   always_comb begin
      wr_ptr_in = emit ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take_res ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = QUEUE_CNT_W'(cnt_ff + QUEUE_CNT_W'(emit) - QUEUE_CNT_W'(take_res));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT;
         held_status_ff <= '0;
         held_first_ff  <= '0;
         held_length_ff <= LEN_ONE;
         chunk_fill_ff  <= '0;
         limit_ff       <= CHUNK_LIMIT_RESET;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         cnt_ff         <= '0;
      end else begin
         phase_ff       <= phase_in;
         held_status_ff <= held_status_in;
         held_first_ff  <= held_first_in;
         held_length_ff <= held_length_in;
         chunk_fill_ff  <= chunk_fill_in;
         if (csr_write_en) begin
            limit_ff <= limit_in;
         end
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         slot_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/midi_byte_stream_message_framer_top.sv @@
// a byte is registered in the front queue, the parser writes results into the result queue
// throughput: one byte per cycle, set by the parser taking one item from its queue a cycle
// while its result queue is not full; both sides have two-entry queues, so a stalled
// consumer does not stop input at once; reset (synchronous, active high) empties both
// queues, returns the parser to waiting for status and sets the sysex chunk limit to 1024
`default_nettype none

module midi_byte_stream_message_framer_top
   import mbf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // byte input
   input  wire logic               push,
   output logic                    full,
   input  wire logic [7:0]         req_midi_byte,
   // result output
   output logic                    empty,
   input  wire logic               pop,
   output logic [1:0]              rsp_kind,
   output logic [7:0]              rsp_status_byte,
   output logic [7:0]              rsp_data_first,
   output logic [7:0]              rsp_data_second,
   output logic [1:0]              rsp_msg_length,
   output logic                    rsp_chunk_last,
   // chunk limit register
   input  wire logic               csr_write_en,
   input  wire logic [CHUNK_W-1:0] csr_write_data
);

   item_type   item;
   logic       item_valid;
   logic       item_take;
   result_type result;

   // front: takes each transfer, classifies the byte and queues it
   mbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .midi_byte  (req_midi_byte),
      .full       (full),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // back: message state machine, holds the limit register and the result queue
   mbf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .pop            (pop),
      .empty          (empty),
      .result         (result)
   );

   // unpack the head of the result queue
   assign rsp_kind        = result.kind;
   assign rsp_status_byte = result.status_byte;
   assign rsp_data_first  = result.data_first;
   assign rsp_data_second = result.data_second;
   assign rsp_msg_length  = result.msg_length;
   assign rsp_chunk_last  = result.chunk_last;

endmodule

`default_nettype wire

@@ hw/rtl/mbf_checker.sv @@
`default_nettype none

module mbf_checker
   import mbf_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               full,
   input wire logic               empty,
   input wire logic               pop,
   input wire logic [1:0]         rsp_kind,
   input wire logic [7:0]         rsp_status_byte,
   input wire logic [1:0]         rsp_msg_length,
   input wire logic               rsp_chunk_last
);

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // chunk end flag only on sysex bytes
   a_last_sysex: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_chunk_last) |-> (rsp_kind == KIND_SYSEX))
      else $error("chunk end on non-sysex result");

   // channel messages carry two or three bytes, others one
   a_length: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_kind == KIND_CHANNEL &&
                   (rsp_msg_length == LEN_TWO || rsp_msg_length == LEN_THREE)) ||
                  (rsp_kind != KIND_CHANNEL && rsp_msg_length == LEN_ONE)))
      else $error("message length does not match kind");

   // a waiting result holds until transferred
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_status_byte) && $stable(rsp_kind)))
      else $error("result changed while stalled");

endmodule

bind midi_byte_stream_message_framer_top mbf_checker u_mbf_checker (.*);

`default_nettype wire
